### hw/rtl/stepper_command_can_framer_assert.svh
// Assertion helpers for the stepper command framer.
// Both forms sample on aclk and are held off while aresetn is low.
`ifndef STEPPER_COMMAND_CAN_FRAMER_ASSERT_SVH
`define STEPPER_COMMAND_CAN_FRAMER_ASSERT_SVH
`ifndef SYNTH
`define SCF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCF_ASSERT_IMPL(lbl, ante, cons, msg)
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/scf_pkg.sv
`default_nettype none

package scf_pkg;

    // request kinds
    typedef enum logic [3:0] {
        REQ_ENABLE      = 4'd0,
        REQ_VELOCITY    = 4'd1,
        REQ_POSITION    = 4'd2,
        REQ_STOP        = 4'd3,
        REQ_SYNC        = 4'd4,
        REQ_RESETPOS    = 4'd5,
        REQ_CLEARSTALL  = 4'd6,
        REQ_PARAM       = 4'd7,
        REQ_SETORIGIN   = 4'd8,
        REQ_TRIGORIGIN  = 4'd9,
        REQ_ABORTORIGIN = 4'd10
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MOTOR = 2'd1,
        ST_BAD_PARAM = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic [2:0] CFG_ADDR0  = 3'd0;
    localparam logic [2:0] CFG_ADDR1  = 3'd1;
    localparam logic [2:0] CFG_INV0   = 3'd2;
    localparam logic [2:0] CFG_INV1   = 3'd3;
    localparam logic [2:0] CFG_MAXRPM = 3'd4;
    localparam logic [2:0] CFG_BCAST  = 3'd5;

    // function bytes
    localparam logic [7:0] FN_ENABLE    = 8'hF3;
    localparam logic [7:0] FN_VELOCITY  = 8'hF6;
    localparam logic [7:0] FN_POSITION  = 8'hFD;
    localparam logic [7:0] FN_STOP      = 8'hFE;
    localparam logic [7:0] FN_SYNC      = 8'hFF;
    localparam logic [7:0] FN_RESETPOS  = 8'h0A;
    localparam logic [7:0] FN_CLRSTALL  = 8'h0E;
    localparam logic [7:0] FN_SETORIGIN = 8'h93;
    localparam logic [7:0] FN_TRIGORIG  = 8'h9A;
    localparam logic [7:0] FN_ABORTORIG = 8'h9C;

    // sub-command and check bytes
    localparam logic [7:0] CHECK_BYTE   = 8'h6B;
    localparam logic [7:0] SUB_ENABLE   = 8'hAB;
    localparam logic [7:0] SUB_STOP     = 8'h98;
    localparam logic [7:0] SUB_SYNC     = 8'h66;
    localparam logic [7:0] SUB_RESETPOS = 8'h6D;
    localparam logic [7:0] SUB_CLRSTALL = 8'h52;
    localparam logic [7:0] SUB_SETORIG  = 8'h88;
    localparam logic [7:0] SUB_ABORTORG = 8'h48;
    localparam logic [7:0] SUB_PARAM12  = 8'h6C;
    localparam logic [7:0] SUB_PARAM13  = 8'h7A;

    localparam logic [3:0] PARAM_SEL12  = 4'd12;
    localparam logic [3:0] PARAM_SEL13  = 4'd13;

    localparam int PAYLOAD_BYTES = 11;
    localparam int FRAME_BYTES   = 7;
    localparam int TARGET_SLOTS  = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // one request as it arrives
    typedef struct packed {
        logic [3:0]  req_type;
        logic [1:0]  motor;
        logic [15:0] signed_rpm;
        logic [31:0] pulses;
        logic [15:0] move_rpm;
        logic [7:0]  accel;
        logic        enable_on;
        logic        absolute;
        logic        sync;
        logic        save_origin;
        logic [7:0]  origin_mode;
        logic [3:0]  param_sel;
    } in_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [7:0]                        addr;
        logic [7:0]                        func;
        logic [PAYLOAD_BYTES-1:0][7:0]     payload;
        logic [3:0]                        nbytes;
        status_t                           status;
        logic [15:0]                       speed;
        logic [31:0]                       pulses;
    } job_t;

    // one outgoing frame
    typedef struct packed {
        logic [15:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        status_t     status;
        logic        last;
        logic [15:0] target_speed;
        logic [31:0] target_pulses;
    } res_t;

    // function byte of a parameter read
    function automatic logic [7:0] param_func(input logic [3:0] sel);
        logic [7:0] f;
        case (sel)
            4'd0:    f = 8'h1F;
            4'd1:    f = 8'h20;
            4'd2:    f = 8'h21;
            4'd3:    f = 8'h24;
            4'd4:    f = 8'h27;
            4'd5:    f = 8'h31;
            4'd6:    f = 8'h33;
            4'd7:    f = 8'h35;
            4'd8:    f = 8'h36;
            4'd9:    f = 8'h37;
            4'd10:   f = 8'h3A;
            4'd11:   f = 8'h3B;
            4'd12:   f = 8'h42;
            4'd13:   f = 8'h43;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/scf_front.sv
`default_nettype none

module scf_front #(
    parameter int MOTOR_COUNT = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire scf_pkg::in_item_t in_item,
    input  wire logic              cfg_valid,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [14:0]       cfg_data,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output scf_pkg::job_t          job
);
    import scf_pkg::*;

    logic [7:0]  addr0_reg, addr1_reg, bcast_reg;
    logic        inv0_reg, inv1_reg;
    logic [14:0] maxrpm_reg;
    logic [15:0] speed_reg [TARGET_SLOTS];
    logic [31:0] pulse_reg [TARGET_SLOTS];

    logic        motor_ok, msel, inv, accept, wr_tgt, known;
    logic [7:0]  addr;
    logic [15:0] cur_spd, new_spd;
    logic [31:0] cur_pul, new_pul;
    logic        rpm_neg, pul_neg;
    logic [16:0] rpm_mag;
    logic [15:0] vel_speed, mv_speed;
    logic [31:0] pul_mag;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign accept    = in_valid && job_ready;

    // motor selection
    assign motor_ok = (32'(in_item.motor) < MOTOR_COUNT) && !in_item.motor[1];
    assign msel     = in_item.motor[0];
    assign addr     = msel ? addr1_reg : addr0_reg;
    assign inv      = msel ? inv1_reg : inv0_reg;
    assign cur_spd  = speed_reg[msel];
    assign cur_pul  = pulse_reg[msel];
    assign known    = in_item.req_type <= REQ_ABORTORIGIN;

    // speed magnitudes and clamps
    assign rpm_neg   = in_item.signed_rpm[15];
    assign rpm_mag   = rpm_neg ? (17'h10000 - {1'b0, in_item.signed_rpm})
                               : {1'b0, in_item.signed_rpm};
    assign vel_speed = (rpm_mag > {2'b00, maxrpm_reg}) ? {1'b0, maxrpm_reg}
                                                       : rpm_mag[15:0];
    assign mv_speed  = (in_item.move_rpm > {1'b0, maxrpm_reg}) ? {1'b0, maxrpm_reg}
                                                               : in_item.move_rpm;
    assign pul_neg   = in_item.pulses[31];
    assign pul_mag   = pul_neg ? (32'd0 - in_item.pulses) : in_item.pulses;

    // build the command bytes
    always_comb begin
        job         = '0;
        job.addr    = addr;
        job.status  = ST_OK;
        new_spd     = cur_spd;
        new_pul     = cur_pul;
        wr_tgt      = 1'b0;
        case (req_t'(in_item.req_type))
            REQ_ENABLE: begin
                job.func       = FN_ENABLE;
                job.payload[0] = SUB_ENABLE;
                job.payload[1] = {7'd0, in_item.enable_on};
                job.payload[3] = CHECK_BYTE;
                job.nbytes     = 4'd4;
            end
            REQ_VELOCITY: begin
                job.func       = FN_VELOCITY;
                job.payload[0] = {7'd0, rpm_neg ^ inv};
                job.payload[1] = vel_speed[15:8];
                job.payload[2] = vel_speed[7:0];
                job.payload[3] = in_item.accel;
                job.payload[4] = {7'd0, in_item.sync};
                job.payload[5] = CHECK_BYTE;
                job.nbytes     = 4'd6;
                new_spd        = in_item.signed_rpm;
                new_pul        = '0;
                wr_tgt         = 1'b1;
            end
            REQ_POSITION: begin
                job.func        = FN_POSITION;
                job.payload[0]  = {7'd0, pul_neg ^ inv};
                job.payload[1]  = mv_speed[15:8];
                job.payload[2]  = mv_speed[7:0];
                job.payload[3]  = in_item.accel;
                job.payload[4]  = pul_mag[31:24];
                job.payload[5]  = pul_mag[23:16];
                job.payload[6]  = pul_mag[15:8];
                job.payload[7]  = pul_mag[7:0];
                job.payload[8]  = {7'd0, in_item.absolute};
                job.payload[9]  = {7'd0, in_item.sync};
                job.payload[10] = CHECK_BYTE;
                job.nbytes      = 4'd11;
                new_spd         = pul_neg ? (16'd0 - mv_speed) : mv_speed;
                new_pul         = in_item.pulses;
                wr_tgt          = 1'b1;
            end
            REQ_STOP: begin
                job.func       = FN_STOP;
                job.payload[0] = SUB_STOP;
                job.payload[1] = {7'd0, in_item.sync};
                job.payload[2] = CHECK_BYTE;
                job.nbytes     = 4'd3;
                new_spd        = '0;
                new_pul        = '0;
                wr_tgt         = 1'b1;
            end
            REQ_SYNC: begin
                job.addr       = bcast_reg;
                job.func       = FN_SYNC;
                job.payload[0] = SUB_SYNC;
                job.payload[1] = CHECK_BYTE;
                job.nbytes     = 4'd2;
            end
            REQ_RESETPOS: begin
                job.func       = FN_RESETPOS;
                job.payload[0] = SUB_RESETPOS;
                job.payload[1] = CHECK_BYTE;
                job.nbytes     = 4'd2;
                new_pul        = '0;
                wr_tgt         = 1'b1;
            end
            REQ_CLEARSTALL: begin
                job.func       = FN_CLRSTALL;
                job.payload[0] = SUB_CLRSTALL;
                job.payload[1] = CHECK_BYTE;
                job.nbytes     = 4'd2;
            end
            REQ_PARAM: begin
                job.func = param_func(in_item.param_sel);
                if (in_item.param_sel > PARAM_SEL13) begin
                    job.status = ST_BAD_PARAM;
                end else if (in_item.param_sel == PARAM_SEL12) begin
                    job.payload[0] = SUB_PARAM12;
                    job.payload[1] = CHECK_BYTE;
                    job.nbytes     = 4'd2;
                end else if (in_item.param_sel == PARAM_SEL13) begin
                    job.payload[0] = SUB_PARAM13;
                    job.payload[1] = CHECK_BYTE;
                    job.nbytes     = 4'd2;
                end else begin
                    job.payload[0] = CHECK_BYTE;
                    job.nbytes     = 4'd1;
                end
            end
            REQ_SETORIGIN: begin
                job.func       = FN_SETORIGIN;
                job.payload[0] = SUB_SETORIG;
                job.payload[1] = {7'd0, in_item.save_origin};
                job.payload[2] = CHECK_BYTE;
                job.nbytes     = 4'd3;
            end
            REQ_TRIGORIGIN: begin
                job.func       = FN_TRIGORIG;
                job.payload[0] = in_item.origin_mode;
                job.payload[1] = {7'd0, in_item.sync};
                job.payload[2] = CHECK_BYTE;
                job.nbytes     = 4'd3;
            end
            REQ_ABORTORIGIN: begin
                job.func       = FN_ABORTORIG;
                job.payload[0] = SUB_ABORTORG;
                job.payload[1] = CHECK_BYTE;
                job.nbytes     = 4'd2;
            end
            default: begin
                job.status = ST_BAD_PARAM;
            end
        endcase

        // bad motor overrides everything except unknown kinds and sync start
        if (known && (in_item.req_type != REQ_SYNC) && !motor_ok) begin
            job        = '0;
            job.status = ST_BAD_MOTOR;
            wr_tgt     = 1'b0;
        end
        if (!motor_ok) begin
            job.speed  = '0;
            job.pulses = '0;
        end else begin
            job.speed  = new_spd;
            job.pulses = new_pul;
        end
        if (job.status != ST_OK) begin
            job.addr    = '0;
            job.func    = '0;
            job.payload = '0;
            job.nbytes  = '0;
        end
    end

    // configuration registers; an address equal to broadcast is refused
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr0_reg  <= 8'd1;
            addr1_reg  <= 8'd2;
            inv0_reg   <= 1'b0;
            inv1_reg   <= 1'b0;
            maxrpm_reg <= 15'd3000;
            bcast_reg  <= 8'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ADDR0:  if (cfg_data[7:0] != bcast_reg) addr0_reg <= cfg_data[7:0];
                CFG_ADDR1:  if (cfg_data[7:0] != bcast_reg) addr1_reg <= cfg_data[7:0];
                CFG_INV0:   inv0_reg   <= cfg_data[0];
                CFG_INV1:   inv1_reg   <= cfg_data[0];
                CFG_MAXRPM: maxrpm_reg <= cfg_data;
                CFG_BCAST:  bcast_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // recorded targets per motor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TARGET_SLOTS; i++) begin
                speed_reg[i] <= '0;
                pulse_reg[i] <= '0;
            end
        end else if (accept && wr_tgt) begin
            speed_reg[msel] <= new_spd;
            pulse_reg[msel] <= new_pul;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/scf_queue.sv
`default_nettype none

module scf_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire scf_pkg::job_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output scf_pkg::job_t      pop_data
);
    import scf_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push_fire, pop_fire;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "stepper_command_can_framer_assert.svh"
    `SCF_ASSERT_NEXT(a_q_fill_up, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1, "queue fill count did not rise on a lone push")

endmodule

`default_nettype wire

### hw/rtl/scf_back.sv
`default_nettype none

module scf_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire scf_pkg::job_t job,
    output logic               m_valid,
    input  wire logic          m_ready,
    output scf_pkg::res_t      m_res
);
    import scf_pkg::*;

    res_t out_reg, out_next;
    job_t hold_reg, hold_next;
    logic out_valid_reg, out_valid_next;
    logic pend_reg, pend_next;
    logic load_ok;

    // first frame of a command, or the single error beat
    function automatic res_t first_frame(input job_t j);
        res_t r;
        r               = '0;
        r.status        = j.status;
        r.target_speed  = j.speed;
        r.target_pulses = j.pulses;
        if (j.status != ST_OK) begin
            r.last = 1'b1;
        end else begin
            r.can_id     = {j.addr, 8'h00};
            r.frame_len  = (j.nbytes > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES + 1)
                                                        : j.nbytes + 4'd1;
            r.frame_data = {j.payload[FRAME_BYTES-1:0], j.func};
            r.last       = j.nbytes <= 4'(FRAME_BYTES);
        end
        return r;
    endfunction

    // second frame carries the tail of the payload
    function automatic res_t second_frame(input job_t j);
        res_t r;
        r               = '0;
        r.status        = ST_OK;
        r.target_speed  = j.speed;
        r.target_pulses = j.pulses;
        r.can_id        = {j.addr, 8'h01};
        r.frame_len     = j.nbytes - 4'(FRAME_BYTES - 1);
        r.frame_data    = {24'd0, j.payload[PAYLOAD_BYTES-1:FRAME_BYTES], j.func};
        r.last          = 1'b1;
        return r;
    endfunction

    assign load_ok   = !out_valid_reg || m_ready;
    assign job_ready = load_ok && !pend_reg;
    assign m_valid   = out_valid_reg;
    assign m_res     = out_reg;

    // output register load
    always_comb begin
        out_next       = out_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !m_ready;
        pend_next      = pend_reg;
        if (load_ok) begin
            if (pend_reg) begin
                out_next       = second_frame(hold_reg);
                out_valid_next = 1'b1;
                pend_next      = 1'b0;
            end else if (job_valid) begin
                out_next       = first_frame(job);
                hold_next      = job;
                out_valid_next = 1'b1;
                pend_next      = (job.status == ST_OK) && (job.nbytes > 4'(FRAME_BYTES));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

`include "stepper_command_can_framer_assert.svh"
    `SCF_ASSERT_IMPL(a_pend_first_shown, pend_reg, out_valid_reg && !out_reg.last, "second frame pending without a first frame on show")
    `SCF_ASSERT_IMPL(a_err_beat_empty, out_valid_reg && (out_reg.status != ST_OK), out_reg.last && (out_reg.frame_len == 4'd0), "error beat carries frame bytes")
    `SCF_ASSERT_NEXT(a_second_follows, pend_reg && m_ready, out_valid_reg && out_reg.last && (out_reg.can_id[7:0] == 8'h01), "second frame did not follow the first")

endmodule

`default_nettype wire

### hw/rtl/stepper_command_can_framer.sv
// Stepper command CAN framer.
// Input stream s_*: one drive request per beat, request kind in s_tuser.
// Output stream m_*: one CAN frame per beat, status in m_tuser, m_tlast on the
// final frame of a request. Position moves give two frames, every other request
// one frame; a bad motor or parameter gives a single empty beat with status set.
// Config channel cfg_*: register index and data, always ready; write only while
// no request is in flight.
// An accepted request passes the queue, then the output register, before its frame
// shows. Throughput: one request per cycle for single-frame commands while m_tready
// stays high; a position move takes the single output register for both its frames.
// A two-entry queue parts the request decoder from the frame builder, so input
// is still taken while a frame waits on m_tready; when the receiver stalls the
// queue fills and s_tready drops, and the shown frame holds.
// Reset: configuration returns to defaults, recorded targets clear to zero, the
// queue and output register empty.
`default_nettype none

module stepper_command_can_framer #(
    parameter int MOTOR_COUNT = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // motor[1:0], signed_rpm[17:2], pulses[49:18], move_rpm[65:50], accel[73:66],
    // enable_on[74], absolute[75], sync[76], save_origin[77], origin_mode[85:78],
    // param_sel[89:86], zero fill above
    input  wire logic [95:0]  s_tdata,
    // req_type[3:0]
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // can_id[15:0], frame_len[19:16], frame_data[83:20], target_speed[99:84],
    // target_pulses[131:100], zero fill above
    output logic [135:0]      m_tdata,
    // status[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [14:0]  cfg_data
);
    import scf_pkg::*;

    in_item_t item;
    job_t     fr_job, q_job;
    res_t     res;
    logic     fr_valid, fr_ready, q_valid, q_ready;

    // unpack the request beat
    assign item.req_type    = s_tuser;
    assign item.motor       = s_tdata[1:0];
    assign item.signed_rpm  = s_tdata[17:2];
    assign item.pulses      = s_tdata[49:18];
    assign item.move_rpm    = s_tdata[65:50];
    assign item.accel       = s_tdata[73:66];
    assign item.enable_on   = s_tdata[74];
    assign item.absolute    = s_tdata[75];
    assign item.sync        = s_tdata[76];
    assign item.save_origin = s_tdata[77];
    assign item.origin_mode = s_tdata[85:78];
    assign item.param_sel   = s_tdata[89:86];

    assign cfg_ready = 1'b1;

    scf_front #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    scf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    scf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res)
    );

    // pack the frame beat
    assign m_tdata = {4'd0, res.target_pulses, res.target_speed, res.frame_data,
                      res.frame_len, res.can_id};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

### bench/tb_stepper_command_can_framer.sv
`timescale 1ns / 1ps

module tb_stepper_command_can_framer;

    import scf_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam int CYCLE_LIMIT   = 200000;

    // register indexes that decode to nothing
    localparam logic [2:0] CFG_SPARE6 = 3'd6;
    localparam logic [2:0] CFG_SPARE7 = 3'd7;

    // request kinds outside the defined set
    localparam logic [3:0] REQ_UNKNOWN_LO = 4'd11;
    localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

    // function byte per readable parameter
    localparam logic [0:13][7:0] PARAM_FN = {
        8'h1F, 8'h20, 8'h21, 8'h24, 8'h27, 8'h31, 8'h33,
        8'h35, 8'h36, 8'h37, 8'h3A, 8'h3B, 8'h42, 8'h43
    };

    typedef struct packed {
        logic [3:0]  req;
        logic [1:0]  motor;
        logic [15:0] rpm;
        logic [31:0] pulses;
        logic [15:0] move_rpm;
        logic [7:0]  accel;
        logic        en;
        logic        absolute;
        logic        sync;
        logic        save;
        logic [7:0]  mode;
        logic [3:0]  psel;
    } drive_req_t;

    typedef struct {
        logic [15:0] can_id;
        logic [3:0]  len;
        logic [63:0] data;
        status_t     status;
        logic        last;
        logic [15:0] tspeed;
        logic [31:0] tpulses;
    } can_frame_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic [95:0]   s_tdata   = '0;
    logic [3:0]    s_tuser   = '0;
    logic          m_tready  = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [14:0]   cfg_data  = '0;
    logic          s_tready;
    logic          m_tvalid;
    logic [135:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;
    logic          cfg_ready;

    // predictor copy of configuration and recorded targets
    logic [7:0]    cfg_addr [0:1] = '{8'd1, 8'd2};
    logic          cfg_inv  [0:1] = '{1'b0, 1'b0};
    logic [14:0]   cfg_max        = 15'd3000;
    logic [7:0]    cfg_bcast      = 8'd0;
    logic [15:0]   speed_rec [0:1] = '{16'd0, 16'd0};
    logic [31:0]   pulse_rec [0:1] = '{32'd0, 32'd0};

    drive_req_t    req_queue [$];
    can_frame_t    frame_q   [$];
    drive_req_t    drv_item;
    logic          in_beat   = 1'b0;

    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            err_cnt   = 0;
    int            n_reqs    = 0;
    int            n_frames  = 0;
    int            n_writes  = 0;
    int            cycles    = 0;

    stepper_command_can_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // expected frames for one accepted request; targets are those after the update
    task automatic predict_request(input drive_req_t r);
        logic [7:0]  pl [0:10];
        logic [7:0]  fn;
        logic [7:0]  addr;
        logic        inv;
        logic        ok_motor;
        logic [31:0] mag;
        logic [15:0] speed;
        logic [7:0]  pkt;
        status_t     st;
        int          n;
        int          idx;
        int          take;
        can_frame_t  f;
        ok_motor = (r.motor < 2'd2);
        addr     = (r.motor == 2'd0) ? cfg_addr[0] : cfg_addr[1];
        inv      = (r.motor == 2'd0) ? cfg_inv[0] : cfg_inv[1];
        st       = ST_OK;
        n        = 0;
        fn       = 8'h00;
        if (r.req > REQ_ABORTORIGIN) begin
            st = ST_BAD_PARAM;
        end else if (r.req == REQ_SYNC) begin
            // sent to the broadcast address even for a bad motor index
            fn = FN_SYNC; addr = cfg_bcast;
            pl[0] = SUB_SYNC; pl[1] = CHECK_BYTE; n = 2;
        end else if (!ok_motor) begin
            st = ST_BAD_MOTOR;
        end else begin
            case (r.req)
                REQ_ENABLE: begin
                    fn = FN_ENABLE;
                    pl[0] = SUB_ENABLE; pl[1] = {7'd0, r.en}; pl[2] = 8'h00;
                    pl[3] = CHECK_BYTE; n = 4;
                end
                REQ_VELOCITY: begin
                    mag   = r.rpm[15] ? (32'h10000 - {16'd0, r.rpm}) : {16'd0, r.rpm};
                    speed = (mag > {17'd0, cfg_max}) ? {1'b0, cfg_max} : mag[15:0];
                    fn = FN_VELOCITY;
                    pl[0] = {7'd0, r.rpm[15] ^ inv};
                    pl[1] = speed[15:8]; pl[2] = speed[7:0]; pl[3] = r.accel;
                    pl[4] = {7'd0, r.sync}; pl[5] = CHECK_BYTE; n = 6;
                    // raw signed speed is recorded, not the clamped one
                    speed_rec[r.motor[0]] = r.rpm;
                    pulse_rec[r.motor[0]] = 32'd0;
                end
                REQ_POSITION: begin
                    mag   = r.pulses[31] ? (32'd0 - r.pulses) : r.pulses;
                    speed = (r.move_rpm > {1'b0, cfg_max}) ? {1'b0, cfg_max} : r.move_rpm;
                    fn = FN_POSITION;
                    pl[0] = {7'd0, r.pulses[31] ^ inv};
                    pl[1] = speed[15:8]; pl[2] = speed[7:0]; pl[3] = r.accel;
                    pl[4] = mag[31:24]; pl[5] = mag[23:16];
                    pl[6] = mag[15:8];  pl[7] = mag[7:0];
                    pl[8] = {7'd0, r.absolute}; pl[9] = {7'd0, r.sync};
                    pl[10] = CHECK_BYTE; n = 11;
                    speed_rec[r.motor[0]] = r.pulses[31] ? (16'd0 - speed) : speed;
                    pulse_rec[r.motor[0]] = r.pulses;
                end
                REQ_STOP: begin
                    fn = FN_STOP;
                    pl[0] = SUB_STOP; pl[1] = {7'd0, r.sync}; pl[2] = CHECK_BYTE; n = 3;
                    speed_rec[r.motor[0]] = 16'd0;
                    pulse_rec[r.motor[0]] = 32'd0;
                end
                REQ_RESETPOS: begin
                    fn = FN_RESETPOS;
                    pl[0] = SUB_RESETPOS; pl[1] = CHECK_BYTE; n = 2;
                    pulse_rec[r.motor[0]] = 32'd0;
                end
                REQ_CLEARSTALL: begin
                    fn = FN_CLRSTALL;
                    pl[0] = SUB_CLRSTALL; pl[1] = CHECK_BYTE; n = 2;
                end
                REQ_PARAM: begin
                    if (r.psel > PARAM_SEL13) begin
                        st = ST_BAD_PARAM;
                    end else begin
                        fn = PARAM_FN[r.psel];
                        if (r.psel == PARAM_SEL12) begin
                            pl[0] = SUB_PARAM12; pl[1] = CHECK_BYTE; n = 2;
                        end else if (r.psel == PARAM_SEL13) begin
                            pl[0] = SUB_PARAM13; pl[1] = CHECK_BYTE; n = 2;
                        end else begin
                            pl[0] = CHECK_BYTE; n = 1;
                        end
                    end
                end
                REQ_SETORIGIN: begin
                    fn = FN_SETORIGIN;
                    pl[0] = SUB_SETORIG; pl[1] = {7'd0, r.save}; pl[2] = CHECK_BYTE; n = 3;
                end
                REQ_TRIGORIGIN: begin
                    fn = FN_TRIGORIG;
                    pl[0] = r.mode; pl[1] = {7'd0, r.sync}; pl[2] = CHECK_BYTE; n = 3;
                end
                default: begin
                    fn = FN_ABORTORIG;
                    pl[0] = SUB_ABORTORG; pl[1] = CHECK_BYTE; n = 2;
                end
            endcase
        end

        f.tspeed  = ok_motor ? speed_rec[r.motor[0]] : 16'd0;
        f.tpulses = ok_motor ? pulse_rec[r.motor[0]] : 32'd0;
        if (st != ST_OK) begin
            // single empty beat carrying the error
            f.can_id = '0; f.len = '0; f.data = '0; f.status = st; f.last = 1'b1;
            if (st == ST_BAD_MOTOR) begin
                f.tspeed = '0; f.tpulses = '0;
            end
            frame_q.push_back(f);
        end else begin
            // cut payload into frames of function byte plus up to seven bytes
            idx = 0;
            pkt = 8'd0;
            while (idx < n) begin
                take = n - idx;
                if (take > FRAME_BYTES) take = FRAME_BYTES;
                f.data = {56'd0, fn};
                for (int i = 0; i < take; i++) f.data[8*(i+1) +: 8] = pl[idx+i];
                idx     += take;
                f.can_id = {addr, pkt};
                f.len    = 4'(take + 1);
                f.status = ST_OK;
                f.last   = (idx >= n);
                frame_q.push_back(f);
                pkt++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // input side: hold a beat until taken, otherwise pick the next or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_beat) begin
            // beat not yet taken
        end else if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_item = req_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= drv_item.req;
            s_tdata  <= {6'd0, drv_item.psel, drv_item.mode, drv_item.save, drv_item.sync,
                         drv_item.absolute, drv_item.en, drv_item.accel, drv_item.move_rpm,
                         drv_item.pulses, drv_item.rpm, drv_item.motor};
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // beats on both streams
    always @(posedge aclk) begin : monitor
        can_frame_t e;
        if (!aresetn) begin
            in_beat <= 1'b0;
        end else begin
            in_beat <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (frame_q.size() == 0) begin
                    $error("result beat with no frame expected, id %0h", m_tdata[15:0]);
                    err_cnt++;
                end else begin
                    e = frame_q.pop_front();
                    check_field("can_id", e.can_id, m_tdata[15:0]);
                    check_field("frame_len", e.len, m_tdata[19:16]);
                    check_field("frame_data", e.data, m_tdata[83:20]);
                    check_field("status", e.status, m_tuser);
                    check_field("last", e.last, m_tlast);
                    check_field("target_speed", e.tspeed, m_tdata[99:84]);
                    check_field("target_pulses", e.tpulses, m_tdata[131:100]);
                    n_frames++;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_request(drv_item);
                n_reqs++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic drive_req_t base_req(input logic [3:0] req, input logic [1:0] motor);
        drive_req_t r;
        r = '0;
        r.req   = req;
        r.motor = motor;
        return r;
    endfunction

    function automatic drive_req_t rand_request();
        drive_req_t  r;
        int unsigned pick;
        r.req   = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 11))
                                           : 4'($urandom_range(10));
        r.motor = ($urandom_range(99) < 10) ? 2'($urandom_range(3, 2))
                                            : 2'($urandom_range(1));
        pick = $urandom_range(9);
        case (pick)
            0:       r.rpm = 16'h8000;
            1:       r.rpm = 16'h7FFF;
            2:       r.rpm = 16'h0000;
            3, 4:    r.rpm = 16'($urandom_range(8000)) - 16'd4000;
            default: r.rpm = 16'($urandom);
        endcase
        pick = $urandom_range(9);
        case (pick)
            0:       r.pulses = 32'h8000_0000;
            1:       r.pulses = 32'h7FFF_FFFF;
            2:       r.pulses = 32'hFFFF_FFFF;
            3:       r.pulses = 32'h0;
            4, 5:    r.pulses = 32'($urandom_range(200000)) - 32'd100000;
            default: r.pulses = $urandom;
        endcase
        r.move_rpm = ($urandom_range(1) == 0) ? 16'($urandom_range(5000)) : 16'($urandom);
        r.accel    = 8'($urandom);
        r.en       = 1'($urandom);
        r.absolute = 1'($urandom);
        r.sync     = 1'($urandom);
        r.save     = 1'($urandom);
        r.mode     = 8'($urandom);
        r.psel     = 4'($urandom_range(15));
        return r;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [14:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ADDR0:  if (val[7:0] != cfg_bcast) cfg_addr[0] = val[7:0];
            CFG_ADDR1:  if (val[7:0] != cfg_bcast) cfg_addr[1] = val[7:0];
            CFG_INV0:   cfg_inv[0] = val[0];
            CFG_INV1:   cfg_inv[1] = val[0];
            CFG_MAXRPM: cfg_max = val;
            CFG_BCAST:  cfg_bcast = val[7:0];
            default:    ;
        endcase
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for all queued requests to go in and all frames to come out
    task automatic wait_idle();
        while (req_queue.size() != 0 || s_tvalid || frame_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input int phase);
        case (phase)
            0: begin
                // broadcast at the top, a write that matches it must be dropped
                cfg_write(CFG_BCAST, 15'h00FF);
                cfg_write(CFG_ADDR0, 15'h00FF);
                cfg_write(CFG_ADDR1, 15'h7FFE);
                cfg_write(CFG_INV0, 15'h0001);
                cfg_write(CFG_INV1, 15'h7FFE);
                cfg_write(CFG_MAXRPM, 15'h0000);
            end
            1: begin
                cfg_write(CFG_BCAST, 15'h7F00);
                cfg_write(CFG_ADDR0, 15'h00FF);
                cfg_write(CFG_ADDR1, 15'h0000);
                cfg_write(CFG_ADDR1, 15'h0001);
                cfg_write(CFG_INV0, 15'h0000);
                cfg_write(CFG_INV1, 15'h7FFF);
                cfg_write(CFG_MAXRPM, 15'h7FFF);
                cfg_write(CFG_SPARE6, 15'h7FFF);
            end
            default: begin
                cfg_write(CFG_BCAST, 15'($urandom));
                cfg_write(CFG_ADDR0, ($urandom_range(3) == 0) ?
                          {7'($urandom), cfg_bcast} : 15'($urandom));
                cfg_write(CFG_ADDR1, ($urandom_range(3) == 0) ?
                          {7'($urandom), cfg_bcast} : 15'($urandom));
                cfg_write(CFG_INV0, 15'($urandom));
                cfg_write(CFG_INV1, 15'($urandom));
                cfg_write(CFG_MAXRPM, ($urandom_range(1) == 0) ?
                          15'($urandom_range(4000)) : 15'($urandom));
                cfg_write(($urandom_range(1) == 0) ? CFG_SPARE6 : CFG_SPARE7,
                          15'($urandom));
            end
        endcase
    endtask

    initial begin
        drive_req_t d;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed pass at reset settings, no idling
        d = base_req(REQ_ENABLE, 2'd0); d.en = 1'b1; req_queue.push_back(d);
        d = base_req(REQ_ENABLE, 2'd1); req_queue.push_back(d);
        d = base_req(REQ_VELOCITY, 2'd0);
        d.rpm = 16'h7FFF; d.accel = 8'hFF; d.sync = 1'b1; req_queue.push_back(d);
        d = base_req(REQ_VELOCITY, 2'd1); d.rpm = 16'h8000; req_queue.push_back(d);
        d = base_req(REQ_VELOCITY, 2'd0); req_queue.push_back(d);
        d = base_req(REQ_POSITION, 2'd0);
        d.pulses = 32'h7FFF_FFFF; d.move_rpm = 16'hFFFF; d.accel = 8'hFF;
        d.absolute = 1'b1; d.sync = 1'b1; req_queue.push_back(d);
        d = base_req(REQ_POSITION, 2'd1); d.pulses = 32'h8000_0000; req_queue.push_back(d);
        d = base_req(REQ_POSITION, 2'd1);
        d.pulses = 32'hFFFF_FFFF; d.move_rpm = 16'd3000; req_queue.push_back(d);
        d = base_req(REQ_STOP, 2'd0); d.sync = 1'b1; req_queue.push_back(d);
        d = base_req(REQ_SYNC, 2'd0); req_queue.push_back(d);
        // sync start still goes out for a bad motor index
        d = base_req(REQ_SYNC, 2'd3); req_queue.push_back(d);
        d = base_req(REQ_RESETPOS, 2'd1); req_queue.push_back(d);
        d = base_req(REQ_CLEARSTALL, 2'd0); req_queue.push_back(d);
        d = base_req(REQ_PARAM, 2'd0); req_queue.push_back(d);
        d = base_req(REQ_PARAM, 2'd1); d.psel = PARAM_SEL12; req_queue.push_back(d);
        d = base_req(REQ_PARAM, 2'd0); d.psel = PARAM_SEL13; req_queue.push_back(d);
        d = base_req(REQ_PARAM, 2'd1); d.psel = 4'd14; req_queue.push_back(d);
        d = base_req(REQ_PARAM, 2'd0); d.psel = 4'd15; req_queue.push_back(d);
        d = base_req(REQ_SETORIGIN, 2'd1); d.save = 1'b1; req_queue.push_back(d);
        d = base_req(REQ_TRIGORIGIN, 2'd0);
        d.mode = 8'hFF; d.sync = 1'b1; req_queue.push_back(d);
        d = base_req(REQ_ABORTORIGIN, 2'd1); req_queue.push_back(d);
        d = base_req(REQ_VELOCITY, 2'd2); d.rpm = 16'h1234; req_queue.push_back(d);
        d = base_req(REQ_POSITION, 2'd3); d.pulses = 32'd1000; req_queue.push_back(d);
        d = base_req(REQ_UNKNOWN_LO, 2'd0); req_queue.push_back(d);
        d = base_req(REQ_UNKNOWN_HI, 2'd3); req_queue.push_back(d);
        wait_idle();

        // random phases, each with new settings and an idling pattern picked by phase
        for (int p = 0; p < RAND_PHASES; p++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            apply_settings(p);
            case (p % 4)
                1:       send_idle_pct = 80;
                2:       recv_stall_pct = 80;
                3:       begin send_idle_pct = 15; recv_stall_pct = 15; end
                default: ;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) req_queue.push_back(rand_request());
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        $display("Ran %0d requests in %0d setting phases plus a directed pass",
                 n_reqs, RAND_PHASES);
        $display("Checked %0d frames, made %0d register writes", n_frames, n_writes);
        if (err_cnt == 0 && frame_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
